// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RGB to YUV 4:2:0 queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rgb2yuv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_pkg
// Types, register indexes and BT.601 coefficients for the RGB to YUV 4:2:0
// converter.
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

  localparam int MAX_DIM_DEFAULT = 4096;

  // configuration port
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0]  FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_DATA_W-1:0]  FRAME_HEIGHT_RESET = 13'd480;

  // coefficients, unsigned with 16 fractional bits
  localparam int COEF_W = 16;
  localparam int PROD_W = 24;
  localparam logic [COEF_W-1:0] K_YR = 16'd16843;
  localparam logic [COEF_W-1:0] K_YG = 16'd33030;
  localparam logic [COEF_W-1:0] K_YB = 16'd6423;
  localparam logic [COEF_W-1:0] K_UR = 16'd9699;
  localparam logic [COEF_W-1:0] K_UG = 16'd19071;
  localparam logic [COEF_W-1:0] K_UB = 16'd28770;
  localparam logic [COEF_W-1:0] K_VR = 16'd28770;
  localparam logic [COEF_W-1:0] K_VG = 16'd24117;
  localparam logic [COEF_W-1:0] K_VB = 16'd4653;
  localparam logic [PROD_W-1:0] LUMA_OFFSET   = 24'(16) << 16;
  localparam logic [PROD_W-1:0] CHROMA_OFFSET = 24'(128) << 16;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       chroma_valid;
    logic       frame_last;
  } yuv_t;

  // one classified pixel waiting for the arithmetic
  typedef struct packed {
    pixel_t pix;
    logic   chroma_valid;
    logic   frame_last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/rgb2yuv_front.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_front
// Frame size registers and raster position counters; tags each accepted pixel
// with its chroma and end-of-frame flags and pushes it to the queue.
// ----------------------------------------------------------------------------
module rgb2yuv_front #(
  parameter int MAX_DIM = rgb2yuv_pkg::MAX_DIM_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_en,
  input  logic [rgb2yuv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rgb2yuv_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  rgb2yuv_pkg::pixel_t                  in_data,
  input  rgb2yuv_pkg::q_status_t               q_status,
  output logic                                 push,
  output rgb2yuv_pkg::job_t                    push_job
);
  import rgb2yuv_pkg::*;

  localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int CMP_W = ($clog2(MAX_DIM + 1) > CFG_DATA_W) ? $clog2(MAX_DIM + 1) : CFG_DATA_W;
  localparam logic [CMP_W-1:0] DIM_MIN = CMP_W'(2);
  localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIM);

  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;
  logic [CNT_W-1:0]      column_count;
  logic [CNT_W-1:0]      row_count;
  logic [CNT_W-1:0]      column_count_next;
  logic [CNT_W-1:0]      row_count_next;
  logic [CMP_W-1:0]      width_raw, height_raw, width_eff, height_eff;
  logic [CMP_W-1:0]      column_plus, row_plus;
  logic                  col_end, row_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate to 2..MAX_DIM
  always_comb begin
    width_raw  = CMP_W'(frame_width);
    height_raw = CMP_W'(frame_height);
    if (width_raw < DIM_MIN)       width_eff = DIM_MIN;
    else if (width_raw > DIM_MAX)  width_eff = DIM_MAX;
    else                           width_eff = width_raw;
    if (height_raw < DIM_MIN)      height_eff = DIM_MIN;
    else if (height_raw > DIM_MAX) height_eff = DIM_MAX;
    else                           height_eff = height_raw;
  end

  // ">=" covers counters left past the end by a lowered register
  assign column_plus = CMP_W'(column_count) + CMP_W'(1);
  assign row_plus    = CMP_W'(row_count) + CMP_W'(1);
  assign col_end     = column_plus >= width_eff;
  assign row_end     = row_plus >= height_eff;

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (col_end) begin
      column_count_next = '0;
      row_count_next    = row_end ? '0 : row_plus[CNT_W-1:0];
    end else begin
      column_count_next = column_plus[CNT_W-1:0];
    end
  end

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (push) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  assign push_job.pix          = in_data;
  assign push_job.chroma_valid = !column_count[0] && !row_count[0];
  assign push_job.frame_last   = col_end && row_end;

endmodule

// ===== rtl/rgb2yuv_queue.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_queue
// Small FIFO of classified pixels between the front and the arithmetic back.
// ----------------------------------------------------------------------------
module rgb2yuv_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  rgb2yuv_pkg::job_t      push_job,
  input  logic                   pop,
  output rgb2yuv_pkg::job_t      pop_job,
  output rgb2yuv_pkg::q_status_t q_status
);
  import rgb2yuv_pkg::*;
  `include "assert_macros.svh"

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign q_status.full  = count == CNT_W'(QUEUE_DEPTH);
  assign q_status.empty = count == '0;
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_job        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
  `ASSERT_NEXT(a_count_up, clk, rst, !rst && do_push && !do_pop, count == $past(count) + CNT_W'(1), "count did not rise on push")
  `ASSERT_NEXT(a_count_down, clk, rst, !rst && do_pop && !do_push, count == $past(count) - CNT_W'(1), "count did not fall on pop")

endmodule

// ===== rtl/rgb2yuv_back.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_back
// Two-stage arithmetic: constant products, then sums, floor and output
// register. The whole pipe advances when the output register can take data.
// ----------------------------------------------------------------------------
module rgb2yuv_back (
  input  logic                   clk,
  input  logic                   rst,
  input  rgb2yuv_pkg::q_status_t q_status,
  input  rgb2yuv_pkg::job_t      pop_job,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rgb2yuv_pkg::yuv_t      out_data
);
  import rgb2yuv_pkg::*;

  logic              advance;
  logic              s1_valid;
  logic              s1_chroma_valid;
  logic              s1_frame_last;
  logic [PROD_W-1:0] p_yr, p_yg, p_yb, p_ur, p_ug, p_ub, p_vr, p_vg, p_vb;
  logic [PROD_W-1:0] luma_sum, cb_sum, cr_sum;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !q_status.empty;

  function automatic logic [PROD_W-1:0] kmul(input logic [COEF_W-1:0] k,
                                             input logic [7:0] v);
    kmul = PROD_W'(k) * PROD_W'(v);
  endfunction

  // stage 1: products
  always_ff @(posedge clk) begin
    if (advance) begin
      p_yr <= kmul(K_YR, pop_job.pix.red);
      p_yg <= kmul(K_YG, pop_job.pix.green);
      p_yb <= kmul(K_YB, pop_job.pix.blue);
      p_ur <= kmul(K_UR, pop_job.pix.red);
      p_ug <= kmul(K_UG, pop_job.pix.green);
      p_ub <= kmul(K_UB, pop_job.pix.blue);
      p_vr <= kmul(K_VR, pop_job.pix.red);
      p_vg <= kmul(K_VG, pop_job.pix.green);
      p_vb <= kmul(K_VB, pop_job.pix.blue);
      s1_chroma_valid <= pop_job.chroma_valid;
      s1_frame_last   <= pop_job.frame_last;
    end
  end

  // stage 2: sums stay within 24 bits and chroma never goes negative
  assign luma_sum = p_yr + p_yg + p_yb + LUMA_OFFSET;
  assign cb_sum   = (p_ub + CHROMA_OFFSET) - (p_ur + p_ug);
  assign cr_sum   = (p_vr + CHROMA_OFFSET) - (p_vg + p_vb);

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.luma         <= luma_sum[23:16];
      out_data.chroma_blue  <= s1_chroma_valid ? cb_sum[23:16] : 8'd0;
      out_data.chroma_red   <= s1_chroma_valid ? cr_sum[23:16] : 8'd0;
      out_data.chroma_valid <= s1_chroma_valid;
      out_data.frame_last   <= s1_frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pop;
      out_valid <= s1_valid;
    end
  end

endmodule

// ===== rtl/rgb_to_yuv420_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter
// BT.601 studio-range RGB to YUV 4:2:0 converter for raster pixel streams.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled and returns one result per pixel,
// in order. Luma comes for every pixel; Cb/Cr come on even rows and even
// columns (top-left of each 2x2 block, no averaging) with chroma_valid set, and
// read zero elsewhere. frame_last marks the last pixel of the frame as set by
// frame_width and frame_height (saturated to 2..MAX_DIM; write them only while
// idle; odd sizes run as given). Throughput is one pixel per cycle while
// neither in_stall nor out_stall is high. An input transfer writes the
// four-entry queue; the constant products are loaded from the queue head, and
// the sums from them go into the output register, which raises out_valid.
// in_stall rises only when the queue is full, so the input keeps flowing while
// a result waits on out_stall, until the queue fills.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter #(
  parameter int MAX_DIM = rgb2yuv_pkg::MAX_DIM_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_en,
  input  logic [rgb2yuv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rgb2yuv_pkg::CFG_DATA_W-1:0]  cfg_data,
  // pixel input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rgb2yuv_pkg::pixel_t                 in_data,
  // YUV output
  output logic                                out_valid,
  input  logic                                out_stall,
  output rgb2yuv_pkg::yuv_t                   out_data
);
  import rgb2yuv_pkg::*;

  q_status_t q_status;
  logic      push;
  job_t      push_job;
  logic      pop;
  job_t      pop_job;

  // front: frame registers, raster counters, pixel tagging
  rgb2yuv_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_job  (push_job)
  );

  // decoupling queue; each side stalls on its own
  rgb2yuv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_status (q_status)
  );

  // back: color matrix pipeline and output register
  rgb2yuv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== bench/rgb_to_yuv420_converter_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_tb
// Self-checking bench for the BT.601 RGB to YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
// A clocked driver feeds pixels from a pending queue and a clocked monitor
// checks every result against a bit-exact model of the conversion and of the
// frame position counters. The run steps through a series of frame sizes:
// the reset size, the smallest, odd sizes, out-of-range values that must
// saturate, and sizes lowered in the middle of a frame. Both sides idle at
// random, except for one long stretch, and the receiver holds off once long
// enough to back the block up into its input.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_tb;
  import rgb2yuv_pkg::*;

  // BT.601 coefficients, 16 fractional bits
  localparam int unsigned Y_FROM_R  = 16843;
  localparam int unsigned Y_FROM_G  = 33030;
  localparam int unsigned Y_FROM_B  = 6423;
  localparam int unsigned CB_FROM_R = 9699;
  localparam int unsigned CB_FROM_G = 19071;
  localparam int unsigned CB_FROM_B = 28770;
  localparam int unsigned CR_FROM_R = 28770;
  localparam int unsigned CR_FROM_G = 24117;
  localparam int unsigned CR_FROM_B = 4653;
  localparam int unsigned Y_BIAS    = 16 << 16;
  localparam int unsigned C_BIAS    = 128 << 16;

  localparam int unsigned DIM_LIMIT = MAX_DIM_DEFAULT;

  // register indexes that decode to nothing
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int DRAIN_CYCLES = 8;      // pipeline is three deep
  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_AT      = 450;    // transfers in before the long hold-off
  localparam int HOLD_CYCLES  = 40;
  localparam int QUIET_FROM   = 700;    // stretch with no idling on either side
  localparam int QUIET_TO     = 900;

  logic clk;
  logic rst = 1'b1;

  logic                   cfg_en    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic   in_valid = 1'b0;
  logic   in_stall;
  pixel_t in_data  = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  yuv_t out_data;

  rgb_to_yuv420_converter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Pixels waiting to be offered, and YUV results waiting to come out.
  pixel_t pixel_queue[$];
  yuv_t   expected_yuv[$];

  // Shadow of the registers and of the frame position.
  logic [CFG_DATA_W-1:0] width_reg  = FRAME_WIDTH_RESET;
  logic [CFG_DATA_W-1:0] height_reg = FRAME_HEIGHT_RESET;
  logic [11:0]           col_pos    = '0;
  logic [11:0]           row_pos    = '0;

  int  pixels_in   = 0;
  int  results_out = 0;
  int  fail_count  = 0;
  int  cycle_count = 0;
  bit  in_taken    = 1'b0;

  // Random idling is off during the quiet stretch.
  function automatic bit idle_allowed();
    return !(pixels_in >= QUIET_FROM && pixels_in < QUIET_TO);
  endfunction

  // Sizes saturate to 2..MAX_DIM; the register keeps what was written.
  function automatic int unsigned eff_dim(logic [CFG_DATA_W-1:0] v);
    if (v < 2) return 2;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  // Converts one pixel and advances the frame position.
  function automatic yuv_t predict_yuv(pixel_t px);
    int unsigned r, g, b, w, h, acc;
    bit          col_end, row_end;
    yuv_t        res;
    r = px.red;
    g = px.green;
    b = px.blue;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    // a counter left past a lowered size counts as the last position
    col_end = (col_pos + 1 >= w);
    row_end = (row_pos + 1 >= h);
    res = '0;
    acc = (Y_FROM_R * r + Y_FROM_G * g + Y_FROM_B * b + Y_BIAS) >> 16;
    res.luma = acc[7:0];
    // chroma only from the top-left pixel of each 2x2 block
    res.chroma_valid = !col_pos[0] && !row_pos[0];
    if (res.chroma_valid) begin
      acc = (C_BIAS + CB_FROM_B * b - CB_FROM_R * r - CB_FROM_G * g) >> 16;
      res.chroma_blue = acc[7:0];
      acc = (C_BIAS + CR_FROM_R * r - CR_FROM_G * g - CR_FROM_B * b) >> 16;
      res.chroma_red = acc[7:0];
    end
    res.frame_last = col_end && row_end;
    if (col_end) begin
      col_pos = '0;
      row_pos = row_end ? 12'd0 : row_pos + 12'd1;
    end else begin
      col_pos = col_pos + 12'd1;
    end
    return res;
  endfunction

  // Components lean on the extremes now and then.
  function automatic logic [7:0] rand_level();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.red   = rand_level();
    px.green = rand_level();
    px.blue  = rand_level();
    return px;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sample at the rising edge. Tracks input transfers for the model,
  // mirrors register writes and checks output transfers in order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    yuv_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      if (!rst && cfg_en) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_reg  = cfg_data;
          REG_FRAME_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      in_taken = !rst && in_valid && !in_stall;
      if (in_taken) begin
        expected_yuv.push_back(predict_yuv(in_data));
        void'(pixel_queue.pop_front());
        pixels_in++;
      end
      if (!rst && out_valid && !out_stall) begin
        if (expected_yuv.size() == 0) begin
          note_failure($sformatf("unexpected result %0d: Y=%0d Cb=%0d Cr=%0d cv=%0d last=%0d",
                                 results_out, out_data.luma, out_data.chroma_blue,
                                 out_data.chroma_red, out_data.chroma_valid,
                                 out_data.frame_last));
        end else begin
          want = expected_yuv.pop_front();
          if (out_data.luma !== want.luma ||
              out_data.chroma_blue !== want.chroma_blue ||
              out_data.chroma_red !== want.chroma_red ||
              out_data.chroma_valid !== want.chroma_valid ||
              out_data.frame_last !== want.frame_last) begin
            note_failure($sformatf(
              "result %0d: expected Y=%0d Cb=%0d Cr=%0d cv=%0d last=%0d, got Y=%0d Cb=%0d Cr=%0d cv=%0d last=%0d",
              results_out, want.luma, want.chroma_blue, want.chroma_red,
              want.chroma_valid, want.frame_last, out_data.luma, out_data.chroma_blue,
              out_data.chroma_red, out_data.chroma_valid, out_data.frame_last));
          end
        end
        results_out++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: change at the falling edge. A pixel on offer stays put until its
  // transfer; otherwise the next pending pixel goes out unless we idle.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pixel_queue.size() != 0 && !(idle_allowed() && $urandom_range(99) < 21)) begin
        in_valid <= 1'b1;
        in_data  <= pixel_queue[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off once enough pixels are in,
  // so the queue inside fills and in_stall must rise.
  // --------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (!hold_done && pixels_in >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_allowed() && ($urandom_range(99) < 21);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequencing
  // --------------------------------------------------------------------------

  // Nothing on offer and nothing outstanding, then let the pipe settle.
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || in_valid || expected_yuv.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_en    <= 1'b0;
  endtask

  // New frame size, then a batch of random pixels. Counters carry over, so a
  // smaller size lands mid-frame with the counters past the new end.
  task automatic run_frame(int unsigned w, int unsigned h, int count);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    repeat (count) pixel_queue.push_back(rand_pixel());
  endtask

  initial begin
    pixel_t px;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every corner of the RGB cube at an even column (chroma taken),
    // each followed by its complement, then alternating bit patterns.
    for (int c = 0; c < 8; c++) begin
      px.red   = c[2] ? 8'hFF : 8'h00;
      px.green = c[1] ? 8'hFF : 8'h00;
      px.blue  = c[0] ? 8'hFF : 8'h00;
      pixel_queue.push_back(px);
      pixel_queue.push_back(~px);
    end
    pixel_queue.push_back('{8'hAA, 8'h55, 8'hAA});
    pixel_queue.push_back('{8'h55, 8'hAA, 8'h55});
    pixel_queue.push_back('{8'h80, 8'h80, 8'h80});
    pixel_queue.push_back('{8'h7F, 8'h7F, 8'h7F});
    pixel_queue.push_back('{8'h01, 8'hFE, 8'h10});
    pixel_queue.push_back('{8'hFE, 8'h01, 8'hEF});

    // reset size, 640 x 480
    repeat (150) pixel_queue.push_back(rand_pixel());

    run_frame(4, 2, 100);        // lowered well below the running column
    run_frame(2, 2, 80);         // smallest frame
    run_frame(0, 1, 60);         // below range, saturates to 2 x 2
    run_frame(16, 8, 240);       // long hold-off falls in here
    run_frame(3, 3, 80);         // odd sizes

    // Above range saturates to MAX_DIM; writes to unused indexes do nothing.
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 8191);
    write_reg(REG_FRAME_HEIGHT, 5);
    write_reg(REG_SPARE_A, 2);
    write_reg(REG_SPARE_B, 8191);
    repeat (60) pixel_queue.push_back(rand_pixel());

    run_frame(4096, 2, 40);      // widest legal row
    run_frame(2, 4096, 200);     // tall frame, row counter climbs
    run_frame(2, 4, 60);         // height lowered under the running row
    run_frame(5, 4, 60);
    run_frame(6, 6, 40);

    wait_idle();
    if (fail_count == 0 && expected_yuv.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
